/* rtl/bba_pkg.sv */
package bba_pkg;

   // Bitmap storage word: 32 block bits per memory word
   localparam int WORD_W     = 32;
   localparam int WORD_SHIFT = 5;

   // Request operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_EXHAUSTED    = 2'd1,
      STATUS_RANGE        = 2'd2,
      STATUS_ALREADY_FREE = 2'd3
   } status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;     // latch the request transaction
      logic load_addr;  // start word address from hint or target
      logic next_addr;  // advance the scan to the next word
      logic commit;     // update bitmap/count and load the response
      logic reply;      // load an error response without a bitmap access
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_alloc;
      logic count_zero;
      logic out_of_range;
      logic word_empty;
      logic rsp_free;
   } dp_status_type;

   // Index of the lowest set bit of a bitmap word
   function automatic logic [WORD_SHIFT-1:0] lowest_set(input logic [WORD_W-1:0] word);
      logic [WORD_SHIFT-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (word[i]) begin
            idx = WORD_SHIFT'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* rtl/bba_ctrl.sv */
module bba_ctrl import bba_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_READ  = 5'b00100,
      ST_EVAL  = 5'b01000,
      ST_REPLY = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Only one request in flight; the response register decouples the output
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.accept = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // exhausted or out-of-range requests never touch the bitmap
            if (dp_status.is_alloc ? dp_status.count_zero : dp_status.out_of_range) begin
               state_in = ST_REPLY;
            end else begin
               dp_cmd.load_addr = 1'b1;
               state_in         = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (dp_status.is_alloc && dp_status.word_empty) begin
               dp_cmd.next_addr = 1'b1;
               state_in         = ST_READ;
            end else if (dp_status.rsp_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (dp_status.rsp_free) begin
               dp_cmd.reply = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/bba_datapath.sv */
module bba_datapath import bba_pkg::*; #(
   parameter int BLOCK_COUNT = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_operation,
   input  logic [9:0]    req_target_block,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type dp_status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic [9:0]    rsp_granted_block,
   output logic [10:0]   rsp_free_count
);

   localparam int NUM_WORDS = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
   localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int FILL_W    = $clog2(NUM_WORDS + 1);
   localparam int CNT_W     = $clog2(BLOCK_COUNT + 1);
   localparam logic [WORD_W-1:0] LAST_MASK = ((BLOCK_COUNT % WORD_W) == 0) ? {WORD_W{1'b1}} :
      ((WORD_W'(1) << (BLOCK_COUNT % WORD_W)) - WORD_W'(1));
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_WORDS - 1);

   // Bitmap memory, 1 = free; words at or above the fill count read as reset value
   logic [WORD_W-1:0] word_mem_ff [NUM_WORDS];
   logic [WORD_W-1:0] mem_q_ff;

   logic              op_ff;
   logic [9:0]        tgt_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] hint_ff, hint_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [9:0]        rsp_grant_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic                  is_alloc;
   logic                  below_fill;
   logic [WORD_W-1:0]     reset_word;
   logic [WORD_W-1:0]     eval_word;
   logic [WORD_SHIFT-1:0] alloc_bit;
   logic [WORD_SHIFT-1:0] tgt_bit;
   logic                  already_free;
   logic [WORD_W-1:0]     wr_word;
   logic                  wr_en;
   logic [ADDR_W-1:0]     tgt_addr;
   logic                  rsp_free;

   assign is_alloc   = (op_ff == OP_ALLOC);
   assign tgt_addr   = ADDR_W'(tgt_ff >> WORD_SHIFT);
   assign tgt_bit    = tgt_ff[WORD_SHIFT-1:0];
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Word as seen by the request: stored data or never-written reset value
   assign below_fill = (FILL_W'(addr_ff) < fill_ff);
   assign reset_word = (addr_ff == LAST_ADDR) ? LAST_MASK : {WORD_W{1'b1}};
   assign eval_word  = below_fill ? mem_q_ff : reset_word;

   assign alloc_bit    = lowest_set(eval_word);
   assign already_free = eval_word[tgt_bit];
   assign wr_word      = is_alloc ? (eval_word & ~(WORD_W'(1) << alloc_bit))
                                  : (eval_word | (WORD_W'(1) << tgt_bit));
   assign wr_en        = dp_cmd.commit && (is_alloc || !already_free);

   // Status back to the controller
   assign dp_status.is_alloc     = is_alloc;
   assign dp_status.count_zero   = (count_ff == '0);
   assign dp_status.out_of_range = (32'(tgt_ff) >= 32'(BLOCK_COUNT));
   assign dp_status.word_empty   = (eval_word == '0);
   assign dp_status.rsp_free     = rsp_free;

   // Request latch
   always_ff @(posedge clock) begin
      if (dp_cmd.accept) begin
         op_ff  <= req_operation;
         tgt_ff <= req_target_block;
      end
   end

   // Bitmap memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_mem_ff[addr_ff] <= wr_word;
      end
      mem_q_ff <= word_mem_ff[addr_ff];
   end

   // Scan address, low-water hint, fill count and free count
   always_comb begin
      addr_in  = addr_ff;
      hint_in  = hint_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      if (dp_cmd.load_addr) begin
         addr_in = is_alloc ? hint_ff : tgt_addr;
      end else if (dp_cmd.next_addr) begin
         addr_in = addr_ff + 1'b1;
      end
      if (wr_en) begin
         if (is_alloc) begin
            count_in = count_ff - 1'b1;
            hint_in  = addr_ff;
         end else begin
            count_in = count_ff + 1'b1;
            if (addr_ff < hint_ff) begin
               hint_in = addr_ff;
            end
         end
         if (FILL_W'(addr_ff) == fill_ff) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= '0;
         hint_ff  <= '0;
         fill_ff  <= '0;
         count_ff <= CNT_W'(BLOCK_COUNT);
      end else begin
         addr_ff  <= addr_in;
         hint_ff  <= hint_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   // Response register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (dp_cmd.commit || dp_cmd.reply) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         if (is_alloc) begin
            rsp_status_ff <= STATUS_OK;
            rsp_grant_ff  <= 10'({addr_ff, alloc_bit});
         end else begin
            rsp_status_ff <= already_free ? STATUS_ALREADY_FREE : STATUS_OK;
            rsp_grant_ff  <= '0;
         end
         rsp_count_ff <= count_in;
      end else if (dp_cmd.reply) begin
         rsp_status_ff <= is_alloc ? STATUS_EXHAUSTED : STATUS_RANGE;
         rsp_grant_ff  <= '0;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_block = rsp_grant_ff;
   assign rsp_free_count    = 11'(rsp_count_ff);

endmodule

/* rtl/bitmap_block_allocator.sv */
// An accepted free or allocate request is checked, its bitmap word is read and tested,
// and the result is loaded into the response register; an allocate repeats the read and
// test for each fully used bitmap word it steps over. Exhausted and out-of-range requests
// skip the bitmap and load an error response. One request at a time: the next is taken at
// the edge after the result is loaded; loading waits while the response register stalls.
// Reset is synchronous; a word fill count makes never-written words read as free.
module bitmap_block_allocator import bba_pkg::*; #(
   parameter int BLOCK_COUNT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [9:0]  req_target_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_granted_block,
   output logic [10:0] rsp_free_count
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Bitmap, counters and response register
   bba_datapath #(
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_target_block  (req_target_block),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_granted_block (rsp_granted_block),
      .rsp_free_count    (rsp_free_count)
   );

endmodule

/* dv/bitmap_block_allocator_tb.sv */
`timescale 1ns / 100ps

module bitmap_block_allocator_tb;
   import bba_pkg::*;

   localparam int MAP_BLOCKS = 1024;

   // One response transaction as the allocator should produce it
   typedef struct {
      status_type  status;
      logic [9:0]  granted;
      logic [10:0] free_count;
   } alloc_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_ALLOC;
   logic [9:0]  req_target_block = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [9:0]  rsp_granted_block;
   logic [10:0] rsp_free_count;

   // Shadow copy of the allocator state
   bit          shadow_free [MAP_BLOCKS];
   int unsigned shadow_free_total;

   alloc_reply_type expected_replies [$];
   int              mismatch_count = 0;
   int              req_idle_pct = 33;
   int              rsp_idle_pct = 33;
   int              rsp_hold_left = 0;

   bitmap_block_allocator #(.BLOCK_COUNT(MAP_BLOCKS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_target_block  (req_target_block),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_granted_block (rsp_granted_block),
      .rsp_free_count    (rsp_free_count)
   );

   always #2 clock = ~clock;

   // First-fit allocate / free on the shadow bitmap, returns the expected reply
   function automatic alloc_reply_type apply_request(logic op, logic [9:0] blk);
      alloc_reply_type r;
      r.status  = STATUS_OK;
      r.granted = '0;
      if (op == OP_ALLOC) begin
         r.status = STATUS_EXHAUSTED;
         for (int i = 0; i < MAP_BLOCKS; i++) begin
            if (shadow_free[i]) begin
               shadow_free[i] = 1'b0;
               if (shadow_free_total > 0) shadow_free_total--;
               r.status  = STATUS_OK;
               r.granted = 10'(i);
               break;
            end
         end
      end else if (int'(blk) >= MAP_BLOCKS) begin
         r.status = STATUS_RANGE;
      end else if (shadow_free[blk]) begin
         r.status = STATUS_ALREADY_FREE;
      end else begin
         shadow_free[blk] = 1'b1;
         if (shadow_free_total < MAP_BLOCKS) shadow_free_total++;
      end
      r.free_count = 11'(shadow_free_total);
      return r;
   endfunction

   // Some block currently in use, searched from a random start; random if none
   function automatic logic [9:0] pick_used_block();
      int start;
      start = $urandom_range(MAP_BLOCKS - 1);
      for (int k = 0; k < MAP_BLOCKS; k++) begin
         if (!shadow_free[(start + k) % MAP_BLOCKS]) return 10'((start + k) % MAP_BLOCKS);
      end
      return 10'(start);
   endfunction

   // Drive one request transaction and record its expected reply on acceptance
   task automatic send_request(input logic op, input logic [9:0] blk);
      alloc_reply_type exp;
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_target_block <= blk;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      exp = apply_request(op, blk);
      expected_replies.push_back(exp);
   endtask

   task automatic go_idle();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_replies(input int limit);
      int n;
      n = 0;
      while (expected_replies.size() != 0 && n < limit) begin
         @(posedge clock);
         n++;
      end
   endtask

   // Response side: long hold-off when asked, random stalls otherwise
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      alloc_reply_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected response status=%0d block=%0d count=%0d",
                        $realtime, rsp_status, rsp_granted_block, rsp_free_count);
         end else begin
            exp = expected_replies.pop_front();
            if (rsp_status !== exp.status || rsp_granted_block !== exp.granted ||
                rsp_free_count !== exp.free_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch exp status=%0d block=%0d count=%0d, got %0d %0d %0d",
                           $realtime, exp.status, exp.granted, exp.free_count,
                           rsp_status, rsp_granted_block, rsp_free_count);
            end
         end
      end
   end

   // Lowest-free selection, double free, extreme block numbers
   task automatic test_directed();
      send_request(OP_ALLOC, 10'd1023);
      send_request(OP_ALLOC, 10'd0);
      send_request(OP_ALLOC, 10'd0);
      send_request(OP_FREE, 10'd1);
      send_request(OP_FREE, 10'd1);
      send_request(OP_ALLOC, 10'd0);
      send_request(OP_FREE, 10'd1023);
      send_request(OP_FREE, 10'd0);
      send_request(OP_FREE, 10'd0);
      send_request(OP_FREE, 10'h2AA);
      send_request(OP_FREE, 10'h155);
      send_request(OP_ALLOC, 10'h3FF);
      send_request(OP_FREE, 10'd2);
   endtask

   // Fill the whole map, then run past exhaustion and recover
   task automatic test_exhaustion();
      while (shadow_free_total != 0) send_request(OP_ALLOC, 10'($urandom));
      send_request(OP_ALLOC, 10'd0);
      send_request(OP_ALLOC, 10'd1023);
      send_request(OP_FREE, 10'd1023);
      send_request(OP_FREE, 10'd1023);
      send_request(OP_ALLOC, 10'd5);
      send_request(OP_ALLOC, 10'd5);
      send_request(OP_FREE, 10'd0);
      send_request(OP_FREE, 10'd512);
      send_request(OP_ALLOC, 10'd0);
   endtask

   // Mostly well-formed traffic: allocs and frees of used blocks, some bad frees
   task automatic test_random_mix(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 45) send_request(OP_ALLOC, 10'($urandom));
         else if (pick < 85) send_request(OP_FREE, pick_used_block());
         else send_request(OP_FREE, 10'($urandom));
      end
   endtask

   // Response side holds off while requests keep coming; then the sender drains
   task automatic test_backpressure();
      rsp_hold_left = 200;
      for (int n = 0; n < 8; n++) begin
         if (n % 2 == 0) send_request(OP_ALLOC, 10'($urandom));
         else send_request(OP_FREE, pick_used_block());
      end
      go_idle();
      wait_for_replies(20000);
      test_random_mix(10);
   endtask

   // Back-to-back traffic with no idling on either side
   task automatic test_full_rate();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_mix(250);
      req_idle_pct = 33;
      rsp_idle_pct = 33;
   endtask

   initial begin
      foreach (shadow_free[i]) shadow_free[i] = 1'b1;
      shadow_free_total = MAP_BLOCKS;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_exhaustion();
      test_random_mix(450);
      test_backpressure();
      test_full_rate();
      go_idle();

      wait_for_replies(50000);
      repeat (100) @(posedge clock);
      mismatch_count += expected_replies.size();
      if (mismatch_count == 0) begin
         $display("bitmap_block_allocator_tb: clean");
      end else begin
         $display("bitmap_block_allocator_tb: errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("bitmap_block_allocator_tb: errors");
      $finish;
   end

endmodule

/* bitmap_block_allocator.f */
rtl/bba_pkg.sv
rtl/bba_ctrl.sv
rtl/bba_datapath.sv
rtl/bitmap_block_allocator.sv
dv/bitmap_block_allocator_tb.sv
